// File: rtl/sced_pkg.sv
package sced_pkg;

	// Default build parameters
	localparam int DEF_MAX_WIDTH    = 1024;
	localparam int DEF_CHANNEL_BITS = 8;

	// Configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_THRESHOLD  = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_THRESHOLD = 2'd3;

	localparam int WIDTH_BITS     = 11;
	localparam int HEIGHT_BITS    = 16;
	localparam int THRESHOLD_BITS = 13;

	localparam logic [WIDTH_BITS-1:0]     RST_IMAGE_WIDTH    = 11'd640;
	localparam logic [HEIGHT_BITS-1:0]    RST_IMAGE_HEIGHT   = 16'd480;
	localparam logic [THRESHOLD_BITS-1:0] RST_LOW_THRESHOLD  = 13'd153;
	localparam logic [THRESHOLD_BITS-1:0] RST_HIGH_THRESHOLD = 13'd383;

	// Gradient direction codes
	typedef logic [1:0] dir_t;
	localparam dir_t DIR_0   = 2'd0;
	localparam dir_t DIR_45  = 2'd1;
	localparam dir_t DIR_90  = 2'd2;
	localparam dir_t DIR_135 = 2'd3;

	// Pixel class codes
	typedef logic [1:0] cls_t;
	localparam cls_t CLS_NONE   = 2'd0;
	localparam cls_t CLS_WEAK   = 2'd1;
	localparam cls_t CLS_STRONG = 2'd2;

endpackage

// File: rtl/sced_pixel_if.sv
interface sced_pixel_if #(
	parameter int CHANNEL_BITS = sced_pkg::DEF_CHANNEL_BITS
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;
	logic                    drain;

	modport source (output valid, red, green, blue, drain, input ready);
	modport sink   (input valid, red, green, blue, drain, output ready);
endinterface

// File: rtl/sced_edge_if.sv
interface sced_edge_if;
	logic valid;
	logic ready;
	logic is_edge;
	logic last_of_frame;

	modport source (output valid, is_edge, last_of_frame, input ready);
	modport sink   (input valid, is_edge, last_of_frame, output ready);
endinterface

// File: rtl/sced_line_mem.sv
// Two-row line store: one entry per column holds {older row, newer row}.
module sced_line_mem #(
	parameter int DEPTH = sced_pkg::DEF_MAX_WIDTH,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [2*WIDTH-1:0]       rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [2*WIDTH-1:0]       wr_data
);
	logic [2*WIDTH-1:0] mem [DEPTH];

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end
endmodule

// File: rtl/sced_sobel.sv
// Sobel sums, strength and quantised direction over three stages (s2..s4).
module sced_sobel #(
	parameter int CHANNEL_BITS = sced_pkg::DEF_CHANNEL_BITS,
	localparam int PW  = 3 * CHANNEL_BITS,
	localparam int MB  = CHANNEL_BITS + 5
) (
	input  logic           clk,
	input  logic           adv,
	input  logic [PW-1:0]  win [9],
	output logic [MB-1:0]  mag,
	output sced_pkg::dir_t dir
);
	localparam int CSB = CHANNEL_BITS + 2;
	localparam int SXB = CHANNEL_BITS + 6;
	localparam int UB  = CHANNEL_BITS + 4;
	localparam int QB  = 2 * MB + 1;

	logic [CSB-1:0]        ch [9];
	logic [SXB-1:0]        px, nx, py, ny;
	logic signed [SXB-1:0] sx, sy, sx_abs, sy_abs;
	logic                  sy_pos;

	logic [UB-1:0] ux_s3, uy_s3;
	logic          sx_zero_s3, sy_zero_s3, sy_pos_s3;

	logic [MB-1:0] sum_s3;
	logic [UB-1:0] diff_s3;

	logic [MB-1:0] mag_s4;
	logic [QB-1:0] sq_sum_s4, sq_diff_s4, two_ux2_s4;
	logic          uy_ge_s4, sx_zero_s4, sy_zero_s4, sy_pos_s4;

	// s2: channel sums and gradients
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			ch[i] = CSB'(win[i][CHANNEL_BITS-1:0]) +
				CSB'(win[i][2*CHANNEL_BITS-1:CHANNEL_BITS]) +
				CSB'(win[i][3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
		end
		px = SXB'(ch[2]) + (SXB'(ch[5]) << 1) + SXB'(ch[8]);
		nx = SXB'(ch[0]) + (SXB'(ch[3]) << 1) + SXB'(ch[6]);
		py = SXB'(ch[0]) + (SXB'(ch[1]) << 1) + SXB'(ch[2]);
		ny = SXB'(ch[6]) + (SXB'(ch[7]) << 1) + SXB'(ch[8]);
		sx = signed'(px - nx);
		sy = signed'(py - ny);
		sx_abs = sx[SXB-1] ? -sx : sx;
		sy_abs = sy[SXB-1] ? -sy : sy;
		// sign of SY once the vector is folded into SX >= 0
		sy_pos = sx[SXB-1] ? sy[SXB-1] : (!sy[SXB-1] && (sy != '0));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ux_s3      <= UB'(sx_abs);
			uy_s3      <= UB'(sy_abs);
			sx_zero_s3 <= (sx == '0);
			sy_zero_s3 <= (sy == '0);
			sy_pos_s3  <= sy_pos;
		end
	end

	// s3: squares for the exact angle tests
	always_comb begin
		sum_s3  = MB'(ux_s3) + MB'(uy_s3);
		diff_s3 = uy_s3 - ux_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s4     <= sum_s3;
			sq_sum_s4  <= QB'(sum_s3) * QB'(sum_s3);
			sq_diff_s4 <= QB'(diff_s3) * QB'(diff_s3);
			two_ux2_s4 <= (QB'(ux_s3) * QB'(ux_s3)) << 1;
			uy_ge_s4   <= (uy_s3 >= ux_s3);
			sx_zero_s4 <= sx_zero_s3;
			sy_zero_s4 <= sy_zero_s3;
			sy_pos_s4  <= sy_pos_s3;
		end
	end

	// s4: direction
	always_comb begin
		if (sx_zero_s4) begin
			dir = sy_zero_s4 ? sced_pkg::DIR_0 : sced_pkg::DIR_90;
		end else if (sq_sum_s4 < two_ux2_s4) begin
			dir = sced_pkg::DIR_0;
		end else if (uy_ge_s4 && (sq_diff_s4 >= two_ux2_s4)) begin
			dir = sced_pkg::DIR_90;
		end else begin
			dir = sy_pos_s4 ? sced_pkg::DIR_45 : sced_pkg::DIR_135;
		end
	end

	assign mag = mag_s4;
endmodule

// File: rtl/sced_top_note.sv
// Hysteresis stage: decides the edge bit from the 3x3 class window.
module sced_hyst (
	input  sced_pkg::cls_t win [9],
	input  logic           border,
	output logic           is_edge
);
	logic any_strong;

	always_comb begin
		any_strong = 1'b0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4 && win[i] == sced_pkg::CLS_STRONG) begin
				any_strong = 1'b1;
			end
		end
		if (border) begin
			is_edge = 1'b0;
		end else if (win[4] == sced_pkg::CLS_STRONG) begin
			is_edge = 1'b1;
		end else if (win[4] == sced_pkg::CLS_WEAK) begin
			is_edge = any_strong;
		end else begin
			is_edge = 1'b0;
		end
	end
endmodule

// File: rtl/sobel_canny_edge_detector_core.sv
// Streaming Sobel/Canny edge detector. RGB pixels enter in raster order and
// one edge bit per pixel leaves in raster order, three rows and three columns
// behind the input; drain items after the last pixel of a frame push out the
// remaining results, and last_of_frame marks the final one. The block takes
// one item per clock while no result is blocked at the output: each of its
// three two-row line memories is read at the column of an item and written
// back by the stage after its read, so each does a single read-modify-write
// per item. The line memories have no clearing pass; the entries they hold
// before first use only feed frame-border positions.
module sobel_canny_edge_detector_core #(
	parameter int MAX_WIDTH    = sced_pkg::DEF_MAX_WIDTH,
	parameter int CHANNEL_BITS = sced_pkg::DEF_CHANNEL_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sced_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [sced_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	sced_pixel_if.sink                          pixels,
	sced_edge_if.source                         edges
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int CS = CW + 2;
	localparam int RS = 19;
	localparam int PW = 3 * CHANNEL_BITS;
	localparam int MB = CHANNEL_BITS + 5;
	localparam int SW = MB + 2;

	typedef struct packed {
		logic signed [RS-1:0] r;
		logic signed [CS-1:0] c;
	} pos_t;

	typedef struct packed {
		logic          valid;
		logic [AW-1:0] a0;
		logic [AW-1:0] a1;
		logic [AW-1:0] a2;
		logic          b1;
		logic          b2;
		logic          b3;
		logic          emit;
		logic          last;
	} ctl_t;

	function automatic pos_t f_pos(input logic [CW-1:0] col, input logic [16:0] row,
			input logic [CW-1:0] wd, input logic [1:0] k);
		pos_t p;
		logic signed [CS-1:0] colx, wx, kc;
		logic signed [RS-1:0] rowx, kr;
		colx = CS'(col);
		wx   = CS'(wd);
		kc   = CS'(k);
		rowx = RS'(row);
		kr   = RS'(k);
		if (colx >= kc) begin
			p.c = colx - kc;
			p.r = rowx - kr;
		end else begin
			p.c = colx + wx - kc;
			p.r = rowx - kr - RS'(1);
		end
		return p;
	endfunction

	function automatic logic f_border(input pos_t p, input logic [CW-1:0] wd,
			input logic [15:0] ht);
		logic signed [RS-1:0] hm1;
		logic signed [CS-1:0] wm1;
		hm1 = RS'(ht) - RS'(1);
		wm1 = CS'(wd) - CS'(1);
		return (p.r < RS'(1)) || (p.r >= hm1) || (p.c < CS'(1)) || (p.c >= wm1);
	endfunction

	// configuration registers
	logic [sced_pkg::WIDTH_BITS-1:0]     cfg_width_q;
	logic [sced_pkg::HEIGHT_BITS-1:0]    cfg_height_q;
	logic [sced_pkg::THRESHOLD_BITS-1:0] cfg_low_q, cfg_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= sced_pkg::RST_IMAGE_WIDTH;
			cfg_height_q <= sced_pkg::RST_IMAGE_HEIGHT;
			cfg_low_q    <= sced_pkg::RST_LOW_THRESHOLD;
			cfg_high_q   <= sced_pkg::RST_HIGH_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sced_pkg::REG_IMAGE_WIDTH:
					cfg_width_q <= cfg_data[sced_pkg::WIDTH_BITS-1:0];
				sced_pkg::REG_IMAGE_HEIGHT:
					cfg_height_q <= cfg_data[sced_pkg::HEIGHT_BITS-1:0];
				sced_pkg::REG_LOW_THRESHOLD:
					cfg_low_q <= cfg_data[sced_pkg::THRESHOLD_BITS-1:0];
				sced_pkg::REG_HIGH_THRESHOLD:
					cfg_high_q <= cfg_data[sced_pkg::THRESHOLD_BITS-1:0];
			endcase
		end
	end

	// saturated frame size
	logic [CW-1:0] wd;
	logic [15:0]   ht;

	always_comb begin
		if (cfg_width_q < 11'd3) begin
			wd = CW'(3);
		end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
			wd = CW'(MAX_WIDTH);
		end else begin
			wd = CW'(cfg_width_q);
		end
		ht = (cfg_height_q < 16'd3) ? 16'd3 : cfg_height_q;
	end

	// pipeline control
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	logic out_valid_q, out_edge_q, out_last_q;
	logic adv, accept, in_frame, take;

	// only a result that cannot leave holds the pipeline
	assign adv = !(out_valid_q && !edges.ready && ctl_s8.valid && ctl_s8.emit);
	assign pixels.ready = adv;
	assign accept = pixels.valid && adv;

	// input position
	logic [CW-1:0] col_q;
	logic [16:0]   row_q;
	pos_t          p1, p2, p3;
	logic          last_now;
	logic [PW-1:0] pix;

	always_comb begin
		logic signed [RS-1:0] hm1;
		logic signed [CS-1:0] wm1;
		hm1 = RS'(ht) - RS'(1);
		wm1 = CS'(wd) - CS'(1);
		in_frame = (row_q < {1'b0, ht});
		take = accept && !(in_frame && pixels.drain);
		pix = in_frame ? {pixels.blue, pixels.green, pixels.red} : '0;
		p1 = f_pos(col_q, row_q, wd, 2'd1);
		p2 = f_pos(col_q, row_q, wd, 2'd2);
		p3 = f_pos(col_q, row_q, wd, 2'd3);
		last_now = !p3.r[RS-1] && ((p3.r > hm1) || ((p3.r == hm1) && (p3.c >= wm1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (last_now) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q + CW'(1) >= wd) begin
				col_q <= '0;
				row_q <= row_q + 17'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// control pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= take;
			ctl_s1.a0    <= col_q[AW-1:0];
			ctl_s1.a1    <= p1.c[AW-1:0];
			ctl_s1.a2    <= p2.c[AW-1:0];
			ctl_s1.b1    <= f_border(p1, wd, ht);
			ctl_s1.b2    <= f_border(p2, wd, ht);
			ctl_s1.b3    <= f_border(p3, wd, ht);
			ctl_s1.emit  <= !p3.r[RS-1];
			ctl_s1.last  <= last_now;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
		end
	end

	// pixel line store and window (s0 read, s1 write back)
	logic [PW-1:0]   pix_s1;
	logic [2*PW-1:0] pm_rd;
	logic [PW-1:0]   pw_q [9];

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= pix;
		end
	end

	sced_line_mem #(.DEPTH(MAX_WIDTH), .WIDTH(PW)) u_pixel_mem (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (col_q[AW-1:0]),
		.rd_data (pm_rd),
		.wr_en   (adv && ctl_s1.valid),
		.wr_addr (ctl_s1.a0),
		.wr_data ({pm_rd[PW-1:0], pix_s1})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				pw_q[i] <= '0;
			end
		end else if (adv && ctl_s1.valid) begin
			pw_q[0] <= pw_q[1];
			pw_q[1] <= pw_q[2];
			pw_q[2] <= pm_rd[2*PW-1:PW];
			pw_q[3] <= pw_q[4];
			pw_q[4] <= pw_q[5];
			pw_q[5] <= pm_rd[PW-1:0];
			pw_q[6] <= pw_q[7];
			pw_q[7] <= pw_q[8];
			pw_q[8] <= pix_s1;
		end
	end

	// Sobel, s2..s4
	logic [MB-1:0]  mag_s4;
	sced_pkg::dir_t dir_s4;

	sced_sobel #(.CHANNEL_BITS(CHANNEL_BITS)) u_sobel (
		.clk (clk),
		.adv (adv),
		.win (pw_q),
		.mag (mag_s4),
		.dir (dir_s4)
	);

	// strength line store and window (s4 read, s5 write back)
	logic [SW-1:0]   sval_s5;
	logic [2*SW-1:0] sm_rd;
	logic [SW-1:0]   sw_q [9];

	always_ff @(posedge clk) begin
		if (adv) begin
			sval_s5 <= ctl_s4.b1 ? '0 : {mag_s4, dir_s4};
		end
	end

	sced_line_mem #(.DEPTH(MAX_WIDTH), .WIDTH(SW)) u_strength_mem (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (ctl_s4.a1),
		.rd_data (sm_rd),
		.wr_en   (adv && ctl_s5.valid),
		.wr_addr (ctl_s5.a1),
		.wr_data ({sm_rd[SW-1:0], sval_s5})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				sw_q[i] <= '0;
			end
		end else if (adv && ctl_s5.valid) begin
			sw_q[0] <= sw_q[1];
			sw_q[1] <= sw_q[2];
			sw_q[2] <= sm_rd[2*SW-1:SW];
			sw_q[3] <= sw_q[4];
			sw_q[4] <= sw_q[5];
			sw_q[5] <= sm_rd[SW-1:0];
			sw_q[6] <= sw_q[7];
			sw_q[7] <= sw_q[8];
			sw_q[8] <= sval_s5;
		end
	end

	// s6: non-maximum suppression and two-threshold class
	logic [MB-1:0]  nms_m, nms_a, nms_b;
	sced_pkg::cls_t cls;

	always_comb begin
		nms_m = sw_q[4][SW-1:2];
		unique case (sw_q[4][1:0])
			sced_pkg::DIR_0: begin
				nms_a = sw_q[3][SW-1:2];
				nms_b = sw_q[5][SW-1:2];
			end
			sced_pkg::DIR_45: begin
				nms_a = sw_q[2][SW-1:2];
				nms_b = sw_q[6][SW-1:2];
			end
			sced_pkg::DIR_90: begin
				nms_a = sw_q[1][SW-1:2];
				nms_b = sw_q[7][SW-1:2];
			end
			sced_pkg::DIR_135: begin
				nms_a = sw_q[0][SW-1:2];
				nms_b = sw_q[8][SW-1:2];
			end
		endcase
		cls = sced_pkg::CLS_NONE;
		if (!ctl_s6.b2 && (32'(nms_m) >= 32'(cfg_low_q)) && (nms_m > nms_a) &&
				(nms_m > nms_b)) begin
			cls = (32'(nms_m) >= 32'(cfg_high_q)) ? sced_pkg::CLS_STRONG
				: sced_pkg::CLS_WEAK;
		end
	end

	// class line store and window (s6 read, s7 write back)
	sced_pkg::cls_t cls_s7;
	logic [3:0]     cm_rd;
	sced_pkg::cls_t cw_q [9];

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s7 <= cls;
		end
	end

	sced_line_mem #(.DEPTH(MAX_WIDTH), .WIDTH(2)) u_class_mem (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (ctl_s6.a2),
		.rd_data (cm_rd),
		.wr_en   (adv && ctl_s7.valid),
		.wr_addr (ctl_s7.a2),
		.wr_data ({cm_rd[1:0], cls_s7})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				cw_q[i] <= sced_pkg::CLS_NONE;
			end
		end else if (adv && ctl_s7.valid) begin
			cw_q[0] <= cw_q[1];
			cw_q[1] <= cw_q[2];
			cw_q[2] <= cm_rd[3:2];
			cw_q[3] <= cw_q[4];
			cw_q[4] <= cw_q[5];
			cw_q[5] <= cm_rd[1:0];
			cw_q[6] <= cw_q[7];
			cw_q[7] <= cw_q[8];
			cw_q[8] <= cls_s7;
		end
	end

	// s8: hysteresis, then the output register
	logic edge_s8;

	sced_hyst u_hyst (
		.win     (cw_q),
		.border  (ctl_s8.b3),
		.is_edge (edge_s8)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && ctl_s8.valid && ctl_s8.emit) begin
			out_valid_q <= 1'b1;
		end else if (edges.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s8.valid && ctl_s8.emit) begin
			out_edge_q <= edge_s8;
			out_last_q <= ctl_s8.last;
		end
	end

	assign edges.valid         = out_valid_q;
	assign edges.is_edge       = out_edge_q;
	assign edges.last_of_frame = out_last_q;

	// checks
	a_hold_on_block: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s8.valid && ctl_s8.emit && out_valid_q && !edges.ready) |-> !pixels.ready)
		else $error("input taken while a result is blocked");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last_now) |=> (col_q == '0 && row_q == '0))
		else $error("counters not cleared after frame end");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < CW'(MAX_WIDTH))
		else $error("column counter beyond line store depth");
endmodule

// File: tb/tb_edge_checker.sv
module tb_edge_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sced_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [sced_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	sced_pixel_if                               pixels,
	sced_edge_if                                edges,
	output int                                  fail_count,
	output int                                  pending
);
	import sced_pkg::*;

	localparam int LINE = 1024;

	typedef struct packed {
		logic is_edge;
		logic last_of_frame;
	} edge_bit_t;

	edge_bit_t edge_q[$];

	// Shadow registers
	logic [WIDTH_BITS-1:0]     img_w;
	logic [HEIGHT_BITS-1:0]    img_h;
	logic [THRESHOLD_BITS-1:0] thr_lo;
	logic [THRESHOLD_BITS-1:0] thr_hi;

	// Line stores and 3x3 windows of the three stages
	int unsigned rgb_line[2*LINE];
	int unsigned rgb_win[9];
	int unsigned mag_line[2*LINE];
	int unsigned mag_win[9];
	int unsigned cls_line[2*LINE];
	int unsigned cls_win[9];
	int          in_row;
	int          in_col;

	assign pending = edge_q.size();

	function automatic void shift_in(ref int unsigned lines[2*LINE], ref int unsigned win[9],
			input int col, input int unsigned v);
		int          i;
		int unsigned up1;
		int unsigned up2;
		i   = col % LINE;
		up1 = lines[i];
		up2 = lines[LINE + i];
		lines[LINE + i] = up1;
		lines[i] = v;
		for (int r = 0; r < 3; r++) begin
			win[r*3]   = win[r*3 + 1];
			win[r*3+1] = win[r*3 + 2];
		end
		win[2] = up2;
		win[5] = up1;
		win[8] = v;
	endfunction

	function automatic longint rgb_sum(int unsigned p);
		return longint'(p & 255) + longint'((p >> 8) & 255) + longint'((p >> 16) & 255);
	endfunction

	// Position of the pixel that a stage k items behind the input works on
	function automatic void lag_pos(int k, int w, output int r, output int c);
		if (in_col >= k) begin
			c = in_col - k;
			r = in_row - k;
		end else begin
			c = in_col + w - k;
			r = in_row - k - 1;
		end
	endfunction

	function automatic bit at_border(int r, int c, int w, int h);
		return r < 1 || r >= h - 1 || c < 1 || c >= w - 1;
	endfunction

	// Angle quantisation, exact on squared integers
	function automatic dir_t grad_dir(longint sx, longint sy);
		longint ux;
		longint uy;
		if (sx < 0) begin
			sx = -sx;
			sy = -sy;
		end
		if (sx == 0) return (sy == 0) ? DIR_0 : DIR_90;
		ux = sx;
		uy = (sy < 0) ? -sy : sy;
		if ((uy + ux) * (uy + ux) < 2 * ux * ux) return DIR_0;
		if (uy >= ux && (uy - ux) * (uy - ux) >= 2 * ux * ux) return DIR_90;
		return (sy > 0) ? DIR_45 : DIR_135;
	endfunction

	// One accepted item through the three stages
	function automatic void edge_step(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
			logic drain);
		int          w;
		int          h;
		int          r;
		int          c;
		int unsigned pix;
		int unsigned str;
		int unsigned cls;
		longint      sx;
		longint      sy;
		longint      mag;
		int unsigned m;
		int unsigned a;
		int unsigned b;
		dir_t        d;
		edge_bit_t   res;
		bit          emitted;
		w = img_w;
		h = img_h;
		pix = 0;
		str = 0;
		cls = CLS_NONE;
		emitted = 0;
		res = '0;
		if (w < 3) w = 3;
		if (w > LINE) w = LINE;
		if (h < 3) h = 3;
		if (in_row < h) begin
			if (drain) return;
			pix = {8'd0, blue, green, red};
		end

		// Sobel strength and direction
		shift_in(rgb_line, rgb_win, in_col, pix);
		lag_pos(1, w, r, c);
		if (!at_border(r, c, w, h)) begin
			sx = rgb_sum(rgb_win[2]) + 2*rgb_sum(rgb_win[5]) + rgb_sum(rgb_win[8])
			   - rgb_sum(rgb_win[0]) - 2*rgb_sum(rgb_win[3]) - rgb_sum(rgb_win[6]);
			sy = rgb_sum(rgb_win[0]) + 2*rgb_sum(rgb_win[1]) + rgb_sum(rgb_win[2])
			   - rgb_sum(rgb_win[6]) - 2*rgb_sum(rgb_win[7]) - rgb_sum(rgb_win[8]);
			mag = ((sx < 0) ? -sx : sx) + ((sy < 0) ? -sy : sy);
			str = (int'(mag) << 2) | int'(grad_dir(sx, sy));
		end

		// Non-maximum suppression and thresholds
		shift_in(mag_line, mag_win, c, str);
		lag_pos(2, w, r, c);
		if (!at_border(r, c, w, h)) begin
			m = mag_win[4] >> 2;
			d = dir_t'(mag_win[4] & 3);
			case (d)
				DIR_0: begin
					a = mag_win[3]; b = mag_win[5];
				end
				DIR_45: begin
					a = mag_win[2]; b = mag_win[6];
				end
				DIR_90: begin
					a = mag_win[1]; b = mag_win[7];
				end
				default: begin
					a = mag_win[0]; b = mag_win[8];
				end
			endcase
			if (m >= thr_lo && m > (a >> 2) && m > (b >> 2))
				cls = (m >= thr_hi) ? CLS_STRONG : CLS_WEAK;
		end

		// Single-pass hysteresis
		shift_in(cls_line, cls_win, c, cls);
		lag_pos(3, w, r, c);
		if (r >= 0) begin
			if (!at_border(r, c, w, h)) begin
				if (cls_win[4] == CLS_STRONG) res.is_edge = 1'b1;
				else if (cls_win[4] == CLS_WEAK)
					for (int i = 0; i < 9; i++)
						if (i != 4 && cls_win[i] == CLS_STRONG) res.is_edge = 1'b1;
			end
			res.last_of_frame = r > h - 1 || (r == h - 1 && c >= w - 1);
			edge_q.push_back(res);
			emitted = 1;
		end

		if (emitted && res.last_of_frame) begin
			in_row = 0;
			in_col = 0;
		end else begin
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		edge_bit_t want;
		if (!arst_n) begin
			img_w  = RST_IMAGE_WIDTH;
			img_h  = RST_IMAGE_HEIGHT;
			thr_lo = RST_LOW_THRESHOLD;
			thr_hi = RST_HIGH_THRESHOLD;
			for (int i = 0; i < 2*LINE; i++) begin
				rgb_line[i] = 0;
				mag_line[i] = 0;
				cls_line[i] = 0;
			end
			for (int i = 0; i < 9; i++) begin
				rgb_win[i] = 0;
				mag_win[i] = 0;
				cls_win[i] = 0;
			end
			in_row = 0;
			in_col = 0;
			fail_count = 0;
			edge_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:    img_w  = cfg_data[WIDTH_BITS-1:0];
					REG_IMAGE_HEIGHT:   img_h  = cfg_data[HEIGHT_BITS-1:0];
					REG_LOW_THRESHOLD:  thr_lo = cfg_data[THRESHOLD_BITS-1:0];
					REG_HIGH_THRESHOLD: thr_hi = cfg_data[THRESHOLD_BITS-1:0];
					default: ;
				endcase
			end
			// result transfer: compare with the oldest expectation
			if (edges.valid && edges.ready) begin
				if (edge_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected edge result: is_edge %0b last %0b",
							edges.is_edge, edges.last_of_frame);
					fail_count++;
				end else begin
					want = edge_q.pop_front();
					if (edges.is_edge !== want.is_edge ||
							edges.last_of_frame !== want.last_of_frame) begin
						if (fail_count < 10)
							$display("edge mismatch: expected is_edge %0b last %0b, got %0b %0b",
								want.is_edge, want.last_of_frame,
								edges.is_edge, edges.last_of_frame);
						fail_count++;
					end
				end
			end
			// pixel transfer
			if (pixels.valid && pixels.ready)
				edge_step(pixels.red, pixels.green, pixels.blue, pixels.drain);
		end
	end
endmodule

// File: tb/tb_top.sv
module tb_top;
	import sced_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	int                        fail_count;
	int                        pending;
	int                        cycles;
	int                        pixels_sent;
	bit                        calm;

	sced_pixel_if pix_ch ();
	sced_edge_if  edge_ch ();

	sobel_canny_edge_detector_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix_ch),
		.edges     (edge_ch)
	);

	tb_edge_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixels     (pix_ch),
		.edges      (edge_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		if (!arst_n) edge_ch.ready <= 1'b0;
		else edge_ch.ready <= calm || ($urandom_range(99) >= 36);
	end

	task automatic reg_write(logic [CFG_INDEX_BITS-1:0] idx, int unsigned val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val[CFG_DATA_BITS-1:0];
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// One pixel-channel transfer, with random gaps ahead of it
	task automatic send_item(logic [23:0] rgb, logic drain);
		while (!calm && $urandom_range(99) < 36) begin
			pix_ch.valid = 1'b0;
			@(negedge clk);
		end
		pix_ch.valid = 1'b1;
		pix_ch.red   = rgb[7:0];
		pix_ch.green = rgb[15:8];
		pix_ch.blue  = rgb[23:16];
		pix_ch.drain = drain;
		#1;
		while (!pix_ch.ready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
	endtask

	// Synthetic scene: noise or a step edge in one of several orientations
	function automatic logic [23:0] scene_pixel(int mode, int row, int col, int k);
		logic [23:0] lo_px;
		logic [23:0] hi_px;
		logic        upper;
		lo_px = 24'($urandom_range(40)) * 24'h010101 + (24'($urandom) & 24'h0f0f0f);
		hi_px = 24'hffffff - lo_px;
		case (mode)
			0: return 24'($urandom);
			1: upper = col < k;
			2: upper = row < k;
			3: upper = row + col < k;
			default: upper = col - row < k - 4;
		endcase
		return upper ? hi_px : lo_px;
	endfunction

	// Whole frame: pixels, then enough flush items to bring out the last result
	task automatic run_frame(int w, int h, int mode, bit stray);
		int k;
		k = $urandom_range(w + h);
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++) begin
				if (stray && $urandom_range(19) == 0) send_item(24'($urandom), 1'b1);
				send_item(scene_pixel(mode, r, c, k), 1'b0);
				pixels_sent++;
			end
		for (int i = 0; i < 3*w + 3; i++)
			send_item(24'($urandom), $urandom_range(3) != 0);
		pix_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic set_frame(int unsigned w, int unsigned h, int unsigned lo, int unsigned hi);
		reg_write(REG_IMAGE_WIDTH, w);
		reg_write(REG_IMAGE_HEIGHT, h);
		reg_write(REG_LOW_THRESHOLD, lo);
		reg_write(REG_HIGH_THRESHOLD, hi);
	endtask

	initial begin
		int          w;
		int          h;
		int unsigned lo;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_IMAGE_WIDTH;
		cfg_data     = '0;
		pix_ch.valid = 1'b0;
		pix_ch.red   = '0;
		pix_ch.green = '0;
		pix_ch.blue  = '0;
		pix_ch.drain = 1'b0;
		cycles       = 0;
		pixels_sent  = 0;
		calm         = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Drains while pixels are still expected are ignored
		send_item(24'h000000, 1'b1);
		send_item(24'hffffff, 1'b1);
		pix_ch.valid = 1'b0;
		repeat (12) @(negedge clk);

		// Directed 5x5 frame under reset thresholds: full-scale diagonal corner
		reg_write(REG_IMAGE_WIDTH, 5);
		reg_write(REG_IMAGE_HEIGHT, 5);
		for (int r = 0; r < 5; r++)
			for (int c = 0; c < 5; c++)
				send_item((r + c < 4) ? 24'hffffff : (r == c ? 24'h00ff00 : 24'h000000), 1'b0);
		for (int i = 0; i < 18; i++) send_item(24'h0, 1'b1);
		pix_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (12) @(negedge clk);

		// Undersized frame saturates to 3x3, zero thresholds
		set_frame(0, 1, 0, 0);
		run_frame(3, 3, 0, 1'b0);

		// No idling on this frame
		calm = 1'b1;
		set_frame(12, 9, 100, 400);
		run_frame(12, 9, 1, 1'b1);
		calm = 1'b0;

		// Crossed and extreme thresholds
		reg_write(REG_IMAGE_HEIGHT, 65535);
		set_frame(9, 3, 8191, 0);
		run_frame(9, 3, 3, 1'b0);
		set_frame(7, 4, 6120, 6120);
		run_frame(7, 4, 4, 1'b0);

		// Random frames of small size
		while (pixels_sent < 280) begin
			w  = $urandom_range(16, 3);
			h  = $urandom_range(10, 3);
			lo = $urandom_range(1500);
			set_frame(w, h, lo, ($urandom_range(4) == 0) ? $urandom_range(lo)
				: lo + $urandom_range(1500));
			run_frame(w, h, $urandom_range(4), 1'b1);
		end

		wait (pending == 0);
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
